>>> rtl/core/assert_macros.svh
// assertion macros shared by the cache rtl
// no dependencies; define SYNTH to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every rising edge, muted while reset is asserted
`define DMC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dmc assertion failed");
// property checked on every rising edge, reset included
`define DMC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
    else $error("dmc assertion failed");
`else
`define DMC_ASSERT(label, clk, rst_n, prop)
`define DMC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> rtl/core/dmc_pkg.sv
// shared codes and constants of the direct-mapped cache core
// no dependencies
`default_nettype none

package dmc_pkg;

    // width of one stored byte
    localparam int BYTE_W = 8;

    // request codes
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // control states
    localparam int STATE_W = 1;
    localparam logic [STATE_W-1:0] ST_IDLE = 1'b0;
    localparam logic [STATE_W-1:0] ST_LOOK = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/dmc_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies; DEPTH must be a power of two
`default_nettype none

module dmc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/direct_mapped_writeback_cache_core.sv
// direct-mapped write-back write-allocate byte cache with its backing store
// no new item is taken until the last leaves lookup; the accept edge reads line store
// and backing row, then lookup checks the tag and does writeback, fill and update at once
// for a read, m_valid is registered as it leaves lookup; a read waits in lookup, and
// holds off the next item, while the result register is full and not taken
// reset starts a clearing pass over max(2^ADDR_BITS/BYTES_PER_LINE, NUM_LINES) addresses
`default_nettype none
`include "assert_macros.svh"

module direct_mapped_writeback_cache_core #(
    parameter int NUM_LINES      = 64,
    parameter int BYTES_PER_LINE = 4,
    parameter int ADDR_BITS      = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_func,
    input  wire logic [ADDR_BITS-1:0] s_address,
    input  wire logic [7:0]           s_write_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [7:0]           m_read_data,
    output logic                      m_hit,
    output logic                      m_dirty
);

    // NUM_LINES and BYTES_PER_LINE must be powers of two (the block does not enforce it);
    // clearing sweeps 16384 addresses at defaults and no item is taken until it ends
    localparam int OFF_W     = $clog2(BYTES_PER_LINE);
    localparam int OFFS_W    = (OFF_W > 0) ? OFF_W : 1;
    localparam int IDX_W     = $clog2(NUM_LINES);
    localparam int ROW_W     = ADDR_BITS - OFF_W;
    localparam int MEM_ROWS  = 1 << ROW_W;
    localparam int TAG_RAW   = ROW_W - IDX_W;
    localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int RX_W      = IDX_W + TAG_W;
    localparam int LINE_W    = BYTES_PER_LINE * dmc_pkg::BYTE_W;
    localparam int LWORD_W   = LINE_W + TAG_W + 2;
    localparam int VALID_BIT = LWORD_W - 1;
    localparam int DIRTY_BIT = LWORD_W - 2;
    localparam int CLR_LEN   = (MEM_ROWS > NUM_LINES) ? MEM_ROWS : NUM_LINES;
    localparam int CLR_W     = $clog2(CLR_LEN);

    // control state
    logic [dmc_pkg::STATE_W-1:0] state_reg, state_next;
    logic                        clearing_reg, clearing_next;
    logic [CLR_W-1:0]            clr_cnt_reg, clr_cnt_next;
    logic                        m_valid_reg, m_valid_next;

    // request held during lookup
    logic              func_reg;
    logic [IDX_W-1:0]  line_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [OFFS_W-1:0] offset_reg;
    logic [7:0]        wdata_reg;

    // result register
    logic [7:0] rdata_reg;
    logic       hit_reg;
    logic       dirty_reg;

    // address split of the incoming item
    logic [ROW_W-1:0]  row_in;
    logic [RX_W-1:0]   rx_in;
    logic [IDX_W-1:0]  line_in;
    logic [TAG_W-1:0]  tag_in;
    logic [OFFS_W-1:0] offset_in;
    logic              accept;

    // memory ports
    logic               lr_we;
    logic [IDX_W-1:0]   lr_waddr;
    logic [LWORD_W-1:0] lr_wdata;
    logic [LWORD_W-1:0] lr_rdata;
    logic               bk_we;
    logic [ROW_W-1:0]   bk_waddr;
    logic [LINE_W-1:0]  bk_wdata;
    logic [LINE_W-1:0]  bk_rdata;

    // lookup datapath
    logic              dir_valid;
    logic              dir_dirty;
    logic [TAG_W-1:0]  dir_tag;
    logic [LINE_W-1:0] dir_data;
    logic              hit;
    logic              victim_wb;
    logic [LINE_W-1:0] base_line;
    logic [LINE_W-1:0] merged_line;
    logic              out_free;
    logic              look_done;
    logic              out_load;
    logic              wb_en;

    // address split
    assign row_in    = ROW_W'(s_address >> OFF_W);
    assign rx_in     = RX_W'(row_in);
    assign line_in   = rx_in[IDX_W-1:0];
    assign tag_in    = rx_in[RX_W-1:IDX_W];
    assign offset_in = OFFS_W'(s_address & ADDR_BITS'(BYTES_PER_LINE - 1));

    assign s_ready = (state_reg == dmc_pkg::ST_IDLE) && !clearing_reg;
    assign accept  = s_valid && s_ready;

    // line store: {valid, dirty, tag, bytes} per line
    dmc_ram #(
        .DEPTH (NUM_LINES),
        .WIDTH (LWORD_W)
    ) u_line_ram (
        .clk   (aclk),
        .we    (lr_we),
        .waddr (lr_waddr),
        .wdata (lr_wdata),
        .re    (accept),
        .raddr (line_in),
        .rdata (lr_rdata)
    );

    // backing store, one line per row
    dmc_ram #(
        .DEPTH (MEM_ROWS),
        .WIDTH (LINE_W)
    ) u_backing_ram (
        .clk   (aclk),
        .we    (bk_we),
        .waddr (bk_waddr),
        .wdata (bk_wdata),
        .re    (accept),
        .raddr (row_in),
        .rdata (bk_rdata)
    );

    // tag check on the line read at accept
    assign dir_valid = lr_rdata[VALID_BIT];
    assign dir_dirty = lr_rdata[DIRTY_BIT];
    assign dir_tag   = lr_rdata[LINE_W +: TAG_W];
    assign dir_data  = lr_rdata[LINE_W-1:0];
    assign hit       = dir_valid && (dir_tag == tag_reg);
    assign victim_wb = dir_valid && dir_dirty && !hit;
    assign base_line = hit ? dir_data : bk_rdata;

    // byte merge for writes
    always_comb begin
        merged_line = base_line;
        for (int i = 0; i < BYTES_PER_LINE; i++) begin
            if (OFFS_W'(i) == offset_reg) begin
                merged_line[i*8 +: 8] = wdata_reg;
            end
        end
    end

    // a read waits in lookup until the result register is free
    assign out_free  = !m_valid_reg || m_ready;
    assign look_done = (state_reg == dmc_pkg::ST_LOOK)
                       && ((func_reg == dmc_pkg::FUNC_WRITE) || out_free);
    assign out_load  = look_done && (func_reg == dmc_pkg::FUNC_READ);
    assign wb_en     = look_done && victim_wb;

    // line store update: zeroed while clearing, fill on a miss, merged byte on a write
    always_comb begin
        if (clearing_reg) begin
            lr_we    = 1'b1;
            lr_waddr = IDX_W'(clr_cnt_reg);
            lr_wdata = '0;
        end else begin
            lr_we    = look_done && ((func_reg == dmc_pkg::FUNC_WRITE) || !hit);
            lr_waddr = line_reg;
            lr_wdata = {1'b1, (func_reg == dmc_pkg::FUNC_WRITE), tag_reg,
                        (func_reg == dmc_pkg::FUNC_WRITE) ? merged_line : base_line};
        end
    end

    // backing store: zero sweep after reset, victim writeback otherwise
    always_comb begin
        if (clearing_reg) begin
            bk_we    = 1'b1;
            bk_waddr = ROW_W'(clr_cnt_reg);
            bk_wdata = '0;
        end else begin
            bk_we    = wb_en;
            bk_waddr = ROW_W'({dir_tag, line_reg});
            bk_wdata = dir_data;
        end
    end

    // next state of control
    always_comb begin
        state_next    = state_reg;
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        m_valid_next  = m_valid_reg;
        if (clearing_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_W'(CLR_LEN - 1)) begin
                clearing_next = 1'b0;
            end
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
        case (state_reg)
            dmc_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = dmc_pkg::ST_LOOK;
                end
            end
            dmc_pkg::ST_LOOK: begin
                if (look_done) begin
                    state_next = dmc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dmc_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dmc_pkg::ST_IDLE;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // capture the item
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg   <= s_func;
            line_reg   <= line_in;
            tag_reg    <= tag_in;
            offset_reg <= offset_in;
            wdata_reg  <= s_write_data;
        end
    end

    // result register; a read miss leaves the line clean
    always_ff @(posedge aclk) begin
        if (out_load) begin
            rdata_reg <= base_line[{offset_reg, 3'b000} +: 8];
            hit_reg   <= hit;
            dirty_reg <= hit && dir_dirty;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = rdata_reg;
    assign m_hit       = hit_reg;
    assign m_dirty     = dirty_reg;

    // checks
    `DMC_ASSERT(a_no_accept_in_clear, aclk, aresetn, clearing_reg |-> !s_ready)
    `DMC_ASSERT(a_accept_to_look, aclk, aresetn, accept |=> (state_reg == dmc_pkg::ST_LOOK))
    `DMC_ASSERT(a_read_miss_clean, aclk, aresetn, (out_load && !hit) |=> (m_valid && !m_hit && !m_dirty))
    `DMC_ASSERT(a_wb_in_lookup, aclk, aresetn, wb_en |-> (state_reg == dmc_pkg::ST_LOOK && !clearing_reg))

endmodule

`default_nettype wire

>>> dv/dmc_access_checker.sv
// cache access checker: watches both channels, mirrors the cache state and
// compares every read item against the mirror; depends on dmc_pkg only
`timescale 1ns / 1ps

module dmc_access_checker #(
    parameter int NUM_LINES      = 64,
    parameter int BYTES_PER_LINE = 4,
    parameter int ADDR_BITS      = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_func,
    input  logic [ADDR_BITS-1:0] s_address,
    input  logic [7:0]           s_write_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [7:0]           m_read_data,
    input  logic                 m_hit,
    input  logic                 m_dirty,
    output int                   failures,
    output int                   pending_reads,
    output int                   read_hits,
    output int                   writebacks
);

    localparam int OFS_W = $clog2(BYTES_PER_LINE);
    localparam int IDX_W = $clog2(NUM_LINES);
    localparam int TAG_W = ADDR_BITS - OFS_W - IDX_W;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] read_data;
        logic       hit;
        logic       dirty;
    } read_result_t;

    // mirror of the backing store and the line array
    logic [7:0]       mem_image  [0:(1 << ADDR_BITS) - 1];
    logic [7:0]       line_data  [0:NUM_LINES * BYTES_PER_LINE - 1];
    logic [TAG_W-1:0] line_tag_q [0:NUM_LINES - 1];
    logic             line_ok    [0:NUM_LINES - 1];
    logic             line_mod   [0:NUM_LINES - 1];

    read_result_t expected_reads[$];
    int fail_n;
    int hit_n;
    int wb_n;

    // apply one access to the mirror, queue the read result if any
    task automatic apply_access(input logic func, input logic [ADDR_BITS-1:0] addr,
                                input logic [7:0] wdata);
        logic [OFS_W-1:0] ofs;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tag;
        logic             is_hit;
        read_result_t     res;
        ofs = addr[OFS_W-1:0];
        idx = addr[OFS_W +: IDX_W];
        tag = addr[ADDR_BITS-1 -: TAG_W];
        is_hit = line_ok[idx] && (line_tag_q[idx] == tag);
        if (!is_hit) begin
            // dirty victim goes home before the fill
            if (line_ok[idx] && line_mod[idx]) begin
                for (int i = 0; i < BYTES_PER_LINE; i++)
                    mem_image[{line_tag_q[idx], idx, OFS_W'(i)}] = line_data[{idx, OFS_W'(i)}];
                wb_n++;
            end
            for (int i = 0; i < BYTES_PER_LINE; i++)
                line_data[{idx, OFS_W'(i)}] = mem_image[{tag, idx, OFS_W'(i)}];
            line_tag_q[idx] = tag;
            line_ok[idx]    = 1'b1;
            line_mod[idx]   = 1'b0;
        end
        if (func == dmc_pkg::FUNC_READ) begin
            res.read_data = line_data[{idx, ofs}];
            res.hit       = is_hit;
            res.dirty     = line_mod[idx];
            if (is_hit)
                hit_n++;
            expected_reads.push_back(res);
        end else begin
            line_data[{idx, ofs}] = wdata;
            line_mod[idx]         = 1'b1;
        end
    endtask

    // compare results first, then take in the new item
    always @(posedge aclk) begin
        read_result_t want;
        if (!aresetn) begin
            foreach (mem_image[i])
                mem_image[i] = '0;
            foreach (line_ok[i]) begin
                line_ok[i]  = 1'b0;
                line_mod[i] = 1'b0;
            end
            expected_reads.delete();
            fail_n = 0;
            hit_n  = 0;
            wb_n   = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reads.size() == 0) begin
                    fail_n++;
                    if (fail_n <= MAX_REPORTS)
                        $display("%0t: unexpected result item data=%02h hit=%0b dirty=%0b",
                                 $realtime, m_read_data, m_hit, m_dirty);
                end else begin
                    want = expected_reads.pop_front();
                    if (m_read_data !== want.read_data || m_hit !== want.hit ||
                        m_dirty !== want.dirty) begin
                        fail_n++;
                        if (fail_n <= MAX_REPORTS)
                            $display("%0t: read mismatch", $realtime,
                                     " exp data=%02h hit=%0b dirty=%0b,",
                                     want.read_data, want.hit, want.dirty,
                                     " got data=%02h hit=%0b dirty=%0b",
                                     m_read_data, m_hit, m_dirty);
                    end
                end
            end
            if (s_valid && s_ready)
                apply_access(s_func, s_address, s_write_data);
        end
        failures      <= fail_n;
        pending_reads <= expected_reads.size();
        read_hits     <= hit_n;
        writebacks    <= wb_n;
    end

endmodule

>>> dv/testbench.sv
// top of the cache testbench: clock, reset, item stimulus and verdict
// depends on dmc_pkg, direct_mapped_writeback_cache_core and dmc_access_checker
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_LINES      = 64;
    localparam int BYTES_PER_LINE = 4;
    localparam int ADDR_BITS      = 16;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int NUM_PHASES     = 4;
    // covers the clearing pass after reset with plenty of margin
    localparam int IDLE_LIMIT     = 60000;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_func       = dmc_pkg::FUNC_READ;
    logic [ADDR_BITS-1:0] s_address    = '0;
    logic [7:0]           s_write_data = '0;
    logic                 m_ready      = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [7:0]           m_read_data;
    logic                 m_hit;
    logic                 m_dirty;

    int failures;
    int pending_reads;
    int read_hits;
    int writebacks;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_reads        = 0;
    int n_writes       = 0;
    logic [7:0] hot_tags [0:2];

    direct_mapped_writeback_cache_core #(
        .NUM_LINES     (NUM_LINES),
        .BYTES_PER_LINE(BYTES_PER_LINE),
        .ADDR_BITS     (ADDR_BITS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_address   (s_address),
        .s_write_data(s_write_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_hit       (m_hit),
        .m_dirty     (m_dirty)
    );

    dmc_access_checker #(
        .NUM_LINES     (NUM_LINES),
        .BYTES_PER_LINE(BYTES_PER_LINE),
        .ADDR_BITS     (ADDR_BITS)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_hit        (m_hit),
        .m_dirty      (m_dirty),
        .failures     (failures),
        .pending_reads(pending_reads),
        .read_hits    (read_hits),
        .writebacks   (writebacks)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any accepted item or taken result
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item accepted for %0d cycles", IDLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // offer one access item, with a random gap in front of it
    task automatic send_access(input logic func, input logic [ADDR_BITS-1:0] addr,
                               input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_address    <= addr;
        s_write_data <= data;
        do @(posedge aclk); while (!s_ready);
        if (func == dmc_pkg::FUNC_READ)
            n_reads++;
        else
            n_writes++;
    endtask

    // hold the sender until every read result has come back
    task automatic drain_reads();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_reads != 0)
            @(posedge aclk);
    endtask

    // mostly a few hot tags on a few lines so hits and evictions are common
    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [7:0] tag;
        logic [5:0] idx;
        logic [1:0] ofs;
        if ($urandom_range(99) < 70) begin
            tag = hot_tags[$urandom_range(2)];
            idx = 6'($urandom_range(7));
            ofs = 2'($urandom_range(3));
            return {tag, idx, ofs};
        end
        return ADDR_BITS'($urandom);
    endfunction

    initial begin
        int send_pcts [0:NUM_PHASES-1];
        int recv_pcts [0:NUM_PHASES-1];
        send_pcts = '{0, 75, 0, 38};
        recv_pcts = '{0, 0, 75, 38};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: cold misses, hits, dirty evictions, refills, extremes
        send_access(dmc_pkg::FUNC_READ,  16'h0000, 8'h00);
        send_access(dmc_pkg::FUNC_READ,  16'h0001, 8'hFF);
        send_access(dmc_pkg::FUNC_WRITE, 16'h0002, 8'hFF);
        send_access(dmc_pkg::FUNC_READ,  16'h0002, 8'h00);
        send_access(dmc_pkg::FUNC_READ,  16'hFFFF, 8'h00);
        send_access(dmc_pkg::FUNC_WRITE, 16'hFFFF, 8'hA5);
        send_access(dmc_pkg::FUNC_WRITE, 16'hFFFC, 8'h5A);
        send_access(dmc_pkg::FUNC_READ,  16'hFFFE, 8'h00);
        send_access(dmc_pkg::FUNC_READ,  16'h3F02, 8'h00);
        send_access(dmc_pkg::FUNC_READ,  16'h0002, 8'h00);
        send_access(dmc_pkg::FUNC_WRITE, 16'h7F03, 8'h00);
        send_access(dmc_pkg::FUNC_WRITE, 16'h7F03, 8'h80);
        send_access(dmc_pkg::FUNC_READ,  16'h7F03, 8'h00);
        send_access(dmc_pkg::FUNC_WRITE, 16'h00FF, 8'h7E);
        send_access(dmc_pkg::FUNC_READ,  16'hFFFF, 8'h00);
        send_access(dmc_pkg::FUNC_READ,  16'hFFFC, 8'h00);
        send_access(dmc_pkg::FUNC_READ,  16'h00FF, 8'h00);
        send_access(dmc_pkg::FUNC_WRITE, 16'h5555, 8'h55);
        send_access(dmc_pkg::FUNC_WRITE, 16'hAAAA, 8'hAA);
        send_access(dmc_pkg::FUNC_READ,  16'h5555, 8'h00);
        send_access(dmc_pkg::FUNC_READ,  16'hAAAA, 8'h00);
        send_access(dmc_pkg::FUNC_READ,  16'h7F03, 8'h00);
        drain_reads();

        // random phases with different idle and stall mixes
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            foreach (hot_tags[t])
                hot_tags[t] = 8'($urandom);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(1) == 0)
                    send_access(dmc_pkg::FUNC_READ, pick_address(), 8'($urandom));
                else
                    send_access(dmc_pkg::FUNC_WRITE, pick_address(), 8'($urandom));
            end
            drain_reads();
        end

        // let any last write settle, then give the verdict
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (20) @(posedge aclk);
        $display("ran %0d read and %0d write items over %0d idle/stall phases",
                 n_reads, n_writes, NUM_PHASES + 1);
        $display("%0d read hits, %0d dirty lines written back, %0d failures",
                 read_hits, writebacks, failures);
        if (failures == 0 && pending_reads == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> direct_mapped_writeback_cache_core.f
+incdir+rtl/core
rtl/core/dmc_pkg.sv
rtl/core/dmc_ram.sv
rtl/core/direct_mapped_writeback_cache_core.sv
dv/dmc_access_checker.sv
dv/testbench.sv
